>>> sv/mjdc_pkg.sv
// Shared constants and helpers for the MJD to calendar date converter.
package mjdc_pkg;

  localparam int unsigned MJD_W   = 17;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned YEAR_W  = 12;

  // B is carried as an offset from B_BASE: B = BOFF + B_BASE.
  localparam int unsigned BOFF_W  = 18;
  localparam int unsigned Z_BASE  = 2400001;
  localparam int unsigned B_BASE  = Z_BASE + 1 + 1524;

  // Gregorian century correction, alpha = floor((4Z - 7468865) / 146097).
  localparam int unsigned ALPHA_W   = 5;
  localparam int unsigned ALPHA_MIN = 14;
  localparam int unsigned ALPHA_MAX = 18;

  // C is carried as an offset from C_BASE: C = COFF + C_BASE.
  localparam int unsigned COFF_W   = 9;
  localparam int unsigned C_BASE   = 6574;
  localparam int unsigned C_DIV    = 7305;
  localparam int unsigned C_NUM_K  = 20 * B_BASE - 2442 - C_BASE * C_DIV;
  localparam int unsigned N2_W     = 22;
  // Exact floor division of an N2_W-bit value by C_DIV via a rounded-up reciprocal.
  localparam int unsigned CDIV_SHIFT = N2_W + 13;
  localparam longint unsigned CDIV_MUL =
    ((64'd1 << CDIV_SHIFT) + C_DIV - 1) / C_DIV;
  localparam int unsigned CDIV_MUL_W = 23;
  localparam int unsigned PROD_W     = N2_W + CDIV_MUL_W;

  // D = floor(1461 C / 4); day-of-year G = B - D kept narrow.
  localparam int unsigned D_MUL     = 1461;
  localparam int unsigned D_REM     = (D_MUL * C_BASE) % 4;
  localparam int unsigned G_OFFSET  = B_BASE - (D_MUL * C_BASE) / 4;
  localparam int unsigned DPROD_W   = 20;
  localparam int unsigned G_W       = 9;

  localparam int unsigned E_W   = 4;
  localparam int unsigned E_MAX = 15;

  localparam int unsigned YEAR_BASE = C_BASE - 4716;

  // Smallest MJD for which alpha reaches k.
  function automatic logic [MJD_W-1:0] alpha_thr(input int unsigned k);
    int unsigned t;
    t = (k * 146097 + 7468865 + 3) / 4 - Z_BASE;
    return MJD_W'(t);
  endfunction

  // Smallest G for which E reaches k: ceil(306001 k / 10000).
  function automatic logic [G_W-1:0] e_thr(input int unsigned k);
    int unsigned t;
    t = (306001 * k + 9999) / 10000;
    return G_W'(t);
  endfunction

  // floor(306001 E / 10000)
  function automatic logic [G_W-1:0] e_day_base(input logic [E_W-1:0] e);
    logic [G_W-1:0] r;
    unique case (e)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd30;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd91;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd183;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd244;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd336;
      4'd12:   r = 9'd367;
      4'd13:   r = 9'd397;
      4'd14:   r = 9'd428;
      default: r = 9'd459;
    endcase
    return r;
  endfunction

  typedef struct packed {
    logic s2;
    logic s3;
  } stage_en_t;

endpackage

>>> sv/mjd_to_calendar_date.sv
// Top level: pipelined Modified Julian Date to Gregorian date converter.
//
//   channel  direction  handshake                 payload
//   input    in         in_valid_i / in_ready_o   mjd_i
//   output   out        out_valid_o / out_ready_i day_o, month_o, year_o
//
// Five register stages: century correction, reciprocal multiply for C,
// day-of-year G, month index E, then the output register.
// One request is taken per cycle while the output is not stalled; an accepted
// request passes through the stage registers above, in that order, before it can leave.
// Reset clears only the stage valid bits; payload registers are not reset.
// Each stage loads when it is empty or its successor moves, so a stall on
// the output holds every filled stage and drops nothing.
module mjd_to_calendar_date
  import mjdc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [MJD_W-1:0]   mjd_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [DAY_W-1:0]   day_o,
  output logic [MONTH_W-1:0] month_o,
  output logic [YEAR_W-1:0]  year_o
);

  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic adv1, adv2, adv3, adv4, adv5;

  logic [ALPHA_W-1:0] alpha;
  logic [ALPHA_W-1:0] alpha_adj;
  logic [BOFF_W-1:0]  boff_d, boff_q;
  stage_en_t          cdiv_en;
  logic [COFF_W-1:0]  coff3;
  logic [G_W-1:0]     g3;

  logic [E_W-1:0]     e_d, e_q;
  logic [COFF_W-1:0]  coff4_q;
  logic [G_W-1:0]     g4_q;

  logic [G_W-1:0]     day_full;
  logic [MONTH_W-1:0] month_d;
  logic [YEAR_W-1:0]  year_d;
  logic [DAY_W-1:0]   day_q;
  logic [MONTH_W-1:0] month_q;
  logic [YEAR_W-1:0]  year_q;

  assign adv5       = !v5_q || out_ready_i;
  assign adv4       = !v4_q || adv5;
  assign adv3       = !v3_q || adv4;
  assign adv2       = !v2_q || adv3;
  assign adv1       = !v1_q || adv2;
  assign in_ready_o = adv1;

  // Stage 1: alpha from threshold compares on the raw day number
  always_comb begin
    alpha = ALPHA_W'(ALPHA_MIN);
    for (int unsigned k = ALPHA_MIN + 1; k <= ALPHA_MAX; k++) begin
      if (mjd_i >= alpha_thr(k)) begin
        alpha = ALPHA_W'(k);
      end
    end
    alpha_adj = alpha - {2'b00, alpha[ALPHA_W-1:2]};
    boff_d    = BOFF_W'(mjd_i) + BOFF_W'(alpha_adj);
  end

  // Stages 2 and 3
  assign cdiv_en.s2 = adv2 && v1_q;
  assign cdiv_en.s3 = adv3 && v2_q;

  mjdc_cdiv u_cdiv (
    .clk_i  (clk_i),
    .en_i   (cdiv_en),
    .boff_i (boff_q),
    .coff_o (coff3),
    .g_o    (g3)
  );

  // Stage 4: month index E from compares on the day of year
  always_comb begin
    e_d = '0;
    for (int unsigned k = 1; k <= E_MAX; k++) begin
      if (g3 >= e_thr(k)) begin
        e_d = E_W'(k);
      end
    end
  end

  // Stage 5: fold E into month, day and year
  always_comb begin
    day_full = g4_q - e_day_base(e_q);
    if (e_q <= MONTH_W'(13)) begin
      month_d = e_q - MONTH_W'(1);
    end else begin
      month_d = e_q - MONTH_W'(13);
    end
    if (month_d > MONTH_W'(2)) begin
      year_d = YEAR_W'(coff4_q) + YEAR_W'(YEAR_BASE);
    end else begin
      year_d = YEAR_W'(coff4_q) + YEAR_W'(YEAR_BASE + 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= in_valid_i;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
      if (adv4) v4_q <= v3_q;
      if (adv5) v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1 && in_valid_i) begin
      boff_q <= boff_d;
    end
    if (adv4 && v3_q) begin
      e_q     <= e_d;
      coff4_q <= coff3;
      g4_q    <= g3;
    end
    if (adv5 && v4_q) begin
      day_q   <= day_full[DAY_W-1:0];
      month_q <= month_d;
      year_q  <= year_d;
    end
  end

  assign out_valid_o = v5_q;
  assign day_o       = day_q;
  assign month_o     = month_q;
  assign year_o      = year_q;

endmodule

>>> sv/mjdc_cdiv.sv
// Year-count division stages: C from B, then day-of-year G = B - D.
module mjdc_cdiv
  import mjdc_pkg::*;
(
  input  logic              clk_i,
  input  stage_en_t         en_i,
  input  logic [BOFF_W-1:0] boff_i,
  output logic [COFF_W-1:0] coff_o,
  output logic [G_W-1:0]    g_o
);

  logic [N2_W-1:0]    n2;
  logic [PROD_W-1:0]  prod_d, prod_q;
  logic [BOFF_W-1:0]  boff_q;
  logic [COFF_W-1:0]  coff_d, coff_q;
  logic [DPROD_W-1:0] dprod;
  logic [BOFF_W:0]    g_full;
  logic [G_W-1:0]     g_d, g_q;

  // 20B - 2442 relative to C_BASE * 7305, then multiply by the reciprocal
  assign n2     = N2_W'({boff_i, 4'b0000}) + N2_W'({boff_i, 2'b00}) + N2_W'(C_NUM_K);
  assign prod_d = PROD_W'(n2) * PROD_W'(CDIV_MUL);

  assign coff_d = prod_q[CDIV_SHIFT +: COFF_W];
  assign dprod  = DPROD_W'(coff_d) * DPROD_W'(D_MUL) + DPROD_W'(D_REM);
  assign g_full = (BOFF_W+1)'(boff_q) + (BOFF_W+1)'(G_OFFSET)
                - (BOFF_W+1)'(dprod[DPROD_W-1:2]);
  assign g_d    = g_full[G_W-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      prod_q <= prod_d;
      boff_q <= boff_i;
    end
    if (en_i.s3) begin
      coff_q <= coff_d;
      g_q    <= g_d;
    end
  end

  assign coff_o = coff_q;
  assign g_o    = g_q;

endmodule
